### hdl/redm_pkg.sv
// Shared types and constants of the rotary encoder decoder with momentum.
// No dependencies; imported by every module under hdl.
`default_nettype none

package redm_pkg;

    // Widths fixed by the stream payload
    localparam int TIME_MS_WIDTH = 32;
    localparam int VALUE_WIDTH   = 16;
    localparam int S_TDATA_WIDTH = 56;
    localparam int M_TDATA_WIDTH = 16;

    // Default storage widths handed to the top level
    localparam int DEF_COUNT_WIDTH = 16;
    localparam int DEF_TIME_WIDTH  = 32;

    // Interval thresholds in ms and the matching step sizes
    localparam int INTERVAL_FAST = 10;
    localparam int INTERVAL_MID  = 20;
    localparam int INTERVAL_SLOW = 50;

    localparam int STEP_WIDTH = 3;
    localparam logic [STEP_WIDTH-1:0] STEP_FAST = 3'd5;
    localparam logic [STEP_WIDTH-1:0] STEP_MID  = 3'd3;
    localparam logic [STEP_WIDTH-1:0] STEP_SLOW = 3'd2;
    localparam logic [STEP_WIDTH-1:0] STEP_ONE  = 3'd1;

    typedef enum logic {
        OP_PIN_EVENT = 1'b0,
        OP_LOAD      = 1'b1
    } op_t;

    typedef struct packed {
        op_t                             op;
        logic                            pin_a;
        logic                            pin_b;
        logic [TIME_MS_WIDTH-1:0]        time_ms;
        logic signed [VALUE_WIDTH-1:0]   write_value;
    } item_t;

endpackage

`default_nettype wire

### hdl/rotary_encoder_decoder_with_momentum.sv
// Rotary encoder decoder with momentum: top level with config and result register.
// Depends on redm_pkg, redm_in_stage and redm_core.
//
// Usage:
//   s_axis carries one request per beat: tuser is the op (0 = pin event,
//   1 = load), tdata the pin levels, the ms timestamp and the load value.
//   m_axis returns exactly one beat per request, the 16-bit count after it.
//   cfg_wen/cfg_wdata write momentum_enable; write it only while idle.
// Stages: two register stages, the input register and then the result register;
//   a request's count is written into the result register as it leaves the input register.
// Throughput: one request per cycle while m_axis_tready stays high; the counter and
//   detent state are updated by a loop around their own registers in redm_core.
// Reset (aresetn low, synchronous): both stages empty, counter, detent state,
//   timestamp and momentum_enable cleared.
// Stall: while m_axis_tready is low the result holds; if the input register is
//   empty one more request is taken into it, then s_axis_tready drops.
`default_nettype none

module rotary_encoder_decoder_with_momentum
    import redm_pkg::*;
#(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
    parameter int TIME_WIDTH  = DEF_TIME_WIDTH
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wen,
    input  wire logic                     cfg_wdata,     // momentum_enable
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [S_TDATA_WIDTH-1:0] s_axis_tdata,  // pin_a, pin_b, time_ms[31:0],
                                                         // write_value[15:0], zero pad
    input  wire logic                     s_axis_tuser,  // op
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic [M_TDATA_WIDTH-1:0]      m_axis_tdata   // count[15:0]
);

    logic                     momentum_reg;
    item_t                    s_item;
    item_t                    item;
    logic                     item_valid;
    logic                     advance;
    logic                     fire;
    logic [M_TDATA_WIDTH-1:0] count_next;
    logic                     m_valid_reg, m_valid_next;
    logic [M_TDATA_WIDTH-1:0] m_data_reg;

    assign s_item.op          = op_t'(s_axis_tuser);
    assign s_item.pin_a       = s_axis_tdata[0];
    assign s_item.pin_b       = s_axis_tdata[1];
    assign s_item.time_ms     = s_axis_tdata[33:2];
    assign s_item.write_value = s_axis_tdata[49:34];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            momentum_reg <= 1'b0;
        end else if (cfg_wen) begin
            momentum_reg <= cfg_wdata;
        end
    end

    // Advance whenever the result register is free or being drained
    assign advance = !m_valid_reg || m_axis_tready;
    assign fire    = item_valid && advance;

    redm_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    redm_core #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .fire            (fire),
        .item            (item),
        .momentum_enable (momentum_reg),
        .count_next      (count_next)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= count_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // A held request must not vanish while the result side stalls
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid && !advance |=> item_valid)
        else $error("stalled request dropped from input register");

    // Every processed request produces a result beat
    a_fire_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_axis_tvalid)
        else $error("processed request produced no result");

    // With an empty result register the input side never blocks
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked while result register empty");

    // A result that is not taken is not overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |-> !fire)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

### hdl/redm_in_stage.sv
// Input register of the encoder decoder: holds one accepted request.
// Depends on redm_pkg for the item type.
`default_nettype none

module redm_in_stage
    import redm_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    input  wire item_t s_item,
    input  wire logic  advance,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  s_fire;

    assign s_ready = !valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (s_fire) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

### hdl/redm_core.sv
// Detent detection, momentum step and position counter of the encoder decoder.
// Depends on redm_pkg for the item type, thresholds and step sizes.
`default_nettype none

module redm_core
    import redm_pkg::*;
#(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
    parameter int TIME_WIDTH  = DEF_TIME_WIDTH
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    fire,
    input  wire item_t                   item,
    input  wire logic                    momentum_enable,
    output logic [M_TDATA_WIDTH-1:0]     count_next
);

    logic                   armed_reg, armed_next;
    logic                   prev_a_reg, prev_a_next;
    logic [TIME_WIDTH-1:0]  last_time_reg, last_time_next;
    logic [COUNT_WIDTH-1:0] position_reg, position_next;

    logic [TIME_WIDTH-1:0]          now;
    logic [TIME_WIDTH-1:0]          interval;
    logic [STEP_WIDTH-1:0]          step;
    logic                           up;
    logic [COUNT_WIDTH+VALUE_WIDTH-1:0] load_ext;
    logic [COUNT_WIDTH+M_TDATA_WIDTH-1:0] count_ext;

    assign now      = item.time_ms[TIME_WIDTH-1:0];
    assign interval = now - last_time_reg;
    assign load_ext = {{COUNT_WIDTH{item.write_value[VALUE_WIDTH-1]}}, item.write_value};
    // At HH a previous low A means down; at LL the sense flips
    assign up       = item.pin_a ? prev_a_reg : !prev_a_reg;

    always_comb begin
        if (!momentum_enable) begin
            step = STEP_ONE;
        end else if (interval < TIME_WIDTH'(INTERVAL_FAST)) begin
            step = STEP_FAST;
        end else if (interval < TIME_WIDTH'(INTERVAL_MID)) begin
            step = STEP_MID;
        end else if (interval < TIME_WIDTH'(INTERVAL_SLOW)) begin
            step = STEP_SLOW;
        end else begin
            step = STEP_ONE;
        end
    end

    always_comb begin
        armed_next     = armed_reg;
        prev_a_next    = prev_a_reg;
        last_time_next = last_time_reg;
        position_next  = position_reg;
        unique case (item.op)
            OP_LOAD: begin
                position_next = load_ext[COUNT_WIDTH-1:0];
            end
            OP_PIN_EVENT: begin
                prev_a_next = item.pin_a;
                if (item.pin_a != item.pin_b) begin
                    armed_next = 1'b1;
                end else if (armed_reg) begin
                    armed_next = 1'b0;
                    if (momentum_enable) begin
                        last_time_next = now;
                    end
                    if (up) begin
                        position_next = position_reg + COUNT_WIDTH'(step);
                    end else begin
                        position_next = position_reg - COUNT_WIDTH'(step);
                    end
                end
            end
            default: begin
                position_next = position_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg     <= 1'b0;
            prev_a_reg    <= 1'b0;
            last_time_reg <= '0;
            position_reg  <= '0;
        end else if (fire) begin
            armed_reg     <= armed_next;
            prev_a_reg    <= prev_a_next;
            last_time_reg <= last_time_next;
            position_reg  <= position_next;
        end
    end

    // Zero-extend or truncate the counter to the 16-bit result
    assign count_ext  = {{M_TDATA_WIDTH{1'b0}}, position_next};
    assign count_next = count_ext[M_TDATA_WIDTH-1:0];

endmodule

`default_nettype wire

### tb/rotary_encoder_decoder_with_momentum_tb.sv
// Stream-level testbench for the rotary encoder decoder with momentum.
// Needs redm_pkg and the RTL under hdl; predicts every count and checks it in order.
`timescale 1ns / 100ps

module rotary_encoder_decoder_with_momentum_tb;
    import redm_pkg::*;

    localparam int CYCLE_LIMIT  = 150000;
    localparam int BATCH_ITEMS  = 230;
    localparam int QUIET_FROM   = 400;
    localparam int QUIET_TO     = 900;
    localparam int IDLE_PERCENT = 13;

    logic                     aclk          = 1'b0;
    logic                     aresetn       = 1'b0;
    logic                     cfg_wen       = 1'b0;
    logic                     cfg_wdata     = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [S_TDATA_WIDTH-1:0] s_axis_tdata  = '0;  // pin_a, pin_b, time_ms, write_value, pad
    logic                     s_axis_tuser  = 1'b0; // op
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [M_TDATA_WIDTH-1:0] m_axis_tdata;        // count

    rotary_encoder_decoder_with_momentum u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Request queue, expected counts and run statistics
    item_t       pending_reqs[$];
    logic [15:0] expected_counts[$];
    item_t       cur_req;
    int          cycle_count    = 0;
    int          error_count    = 0;
    int          reqs_accepted  = 0;
    int          counts_checked = 0;
    int          loads_seen     = 0;
    int          detents_seen   = 0;
    int          phases_run     = 0;

    // Predictor state of the decoder
    logic        momentum_on;
    logic        enc_armed;
    logic        enc_prev_a;
    logic [31:0] enc_last_time;
    logic [15:0] enc_position;

    // Stimulus generator state
    logic [31:0] gen_time;
    int          gen_phase;
    logic        gen_up;

    function automatic logic [15:0] predict_count(input item_t req);
        logic [31:0] interval;
        logic [15:0] step;
        logic        up;
        if (req.op == OP_LOAD) begin
            enc_position = req.write_value;
            loads_seen++;
        end else begin
            if (req.pin_a == req.pin_b) begin
                if (enc_armed) begin
                    step = 16'd1;
                    if (momentum_on) begin
                        interval = req.time_ms - enc_last_time;
                        enc_last_time = req.time_ms;
                        if (interval < INTERVAL_FAST)
                            step = 16'd5;
                        else if (interval < INTERVAL_MID)
                            step = 16'd3;
                        else if (interval < INTERVAL_SLOW)
                            step = 16'd2;
                    end
                    up = req.pin_a ? enc_prev_a : !enc_prev_a;
                    enc_position = up ? enc_position + step : enc_position - step;
                    enc_armed = 1'b0;
                    detents_seen++;
                end
            end else begin
                enc_armed = 1'b1;
            end
            enc_prev_a = req.pin_a;
        end
        return enc_position;
    endfunction

    function automatic logic idle_roll();
        if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO)
            return 1'b0;
        return $urandom_range(0, 99) < IDLE_PERCENT;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("MISMATCH at cycle %0d: %s, count got %h expected %h",
                 cycle_count, what, got, want);
        error_count++;
    endtask

    task automatic add_pin(input logic a, input logic b, input logic [31:0] t);
        item_t req;
        req.op          = OP_PIN_EVENT;
        req.pin_a       = a;
        req.pin_b       = b;
        req.time_ms     = t;
        req.write_value = 16'($urandom);
        pending_reqs.push_back(req);
    endtask

    task automatic add_load(input logic [15:0] v, input logic a, input logic b,
                            input logic [31:0] t);
        item_t req;
        req.op          = OP_LOAD;
        req.pin_a       = a;
        req.pin_b       = b;
        req.time_ms     = t;
        req.write_value = v;
        pending_reqs.push_back(req);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_counts.size() != 0)
            @(negedge aclk);
    endtask

    // Write the register while nothing is in flight
    task automatic write_momentum(input logic enable);
        wait_idle();
        @(posedge aclk);
        cfg_wen     <= 1'b1;
        cfg_wdata   <= enable;
        momentum_on = enable;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        @(negedge aclk);
        phases_run++;
    endtask

    function automatic logic [31:0] next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(0, 30);
        if (r < 95)
            return $urandom_range(31, 5000);
        return $urandom;
    endfunction

    // Mostly clean quadrature rotation, with loads, glitches and time jumps mixed in
    task automatic add_random_batch(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 199) == 0)
                gen_time = 32'hFFFF_FFC0 + $urandom_range(0, 63);
            else
                gen_time = gen_time + next_gap();
            if (r < 7) begin
                case ($urandom_range(0, 5))
                    0: add_load(16'h7FFF, 1'($urandom), 1'($urandom), $urandom);
                    1: add_load(16'h8000, 1'($urandom), 1'($urandom), $urandom);
                    default: add_load(16'($urandom), 1'($urandom), 1'($urandom), $urandom);
                endcase
            end else if (r < 16) begin
                add_pin(1'($urandom), 1'($urandom), gen_time);
            end else begin
                if ($urandom_range(0, 9) == 0)
                    gen_up = !gen_up;
                gen_phase = gen_up ? (gen_phase + 1) % 4 : (gen_phase + 3) % 4;
                // walk the Gray sequence 00, 10, 11, 01 (a, b)
                add_pin(gen_phase == 1 || gen_phase == 2, gen_phase >= 2, gen_time);
            end
        end
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("rotary_encoder_decoder_with_momentum_tb failed");
            $finish;
        end
    end

    // Request driver: predict on acceptance, then present the next request or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_counts.push_back(predict_count(cur_req));
                reqs_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_reqs.size() != 0 && !idle_roll()) begin
                    cur_req = pending_reqs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= cur_req.op;
                    s_axis_tdata  <= {6'b0, cur_req.write_value, cur_req.time_ms,
                                      cur_req.pin_b, cur_req.pin_a};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_counts.size() == 0) begin
                    report_mismatch("result with no request pending", m_axis_tdata, 16'h0);
                end else begin
                    if (m_axis_tdata !== expected_counts[0])
                        report_mismatch("wrong count", m_axis_tdata, expected_counts[0]);
                    void'(expected_counts.pop_front());
                    counts_checked++;
                end
            end
            m_axis_tready <= !idle_roll();
        end
    end

    initial begin
        momentum_on   = 1'b0;
        enc_armed     = 1'b0;
        enc_prev_a    = 1'b0;
        enc_last_time = '0;
        enc_position  = '0;
        gen_time      = '0;
        gen_phase     = 0;
        gen_up        = 1'b1;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Fixed step: overflow both ways, both directions at HH and LL, unarmed detent
        write_momentum(1'b0);
        add_load(16'h7FFF, 1'b0, 1'b0, 32'h0);
        add_pin(1'b1, 1'b0, 32'd1);
        add_pin(1'b1, 1'b1, 32'd2);
        add_pin(1'b0, 1'b1, 32'd3);
        add_pin(1'b0, 1'b0, 32'd4);
        add_pin(1'b0, 1'b0, 32'd5);
        add_pin(1'b1, 1'b0, 32'd6);
        add_pin(1'b0, 1'b0, 32'd7);
        add_load(16'h8000, 1'b1, 1'b1, 32'hFFFF_FFFF);
        add_pin(1'b0, 1'b1, 32'd8);
        add_pin(1'b1, 1'b1, 32'd9);

        // Momentum: each interval threshold, then a timestamp wrap
        write_momentum(1'b1);
        add_pin(1'b1, 1'b0, 32'd3);
        add_pin(1'b1, 1'b1, 32'd9);
        add_pin(1'b0, 1'b1, 32'd12);
        add_pin(1'b0, 1'b0, 32'd19);
        add_pin(1'b1, 1'b0, 32'd30);
        add_pin(1'b0, 1'b0, 32'd38);
        add_pin(1'b0, 1'b1, 32'd50);
        add_pin(1'b1, 1'b1, 32'd58);
        add_pin(1'b1, 1'b0, 32'd90);
        add_pin(1'b1, 1'b1, 32'd107);
        add_pin(1'b0, 1'b1, 32'd130);
        add_pin(1'b0, 1'b0, 32'd157);
        add_pin(1'b1, 1'b0, 32'hFFFF_FFF0);
        add_pin(1'b1, 1'b1, 32'hFFFF_FFFD);
        add_pin(1'b0, 1'b1, 32'hFFFF_FFFF);
        add_pin(1'b0, 1'b0, 32'd4);

        gen_time = 32'd200;
        for (int p = 0; p < 6; p++) begin
            write_momentum(p % 2 == 0 || p == 5);
            add_random_batch(BATCH_ITEMS);
        end

        wait_idle();
        repeat (4) @(posedge aclk);
        $display("covered %0d requests (%0d loads, %0d detents) over %0d register settings",
                 reqs_accepted, loads_seen, detents_seen, phases_run);
        $display("checked %0d counts, %0d mismatches", counts_checked, error_count);
        if (error_count == 0)
            $display("rotary_encoder_decoder_with_momentum_tb passed");
        else
            $display("rotary_encoder_decoder_with_momentum_tb failed");
        $finish;
    end

endmodule

### files.f
hdl/redm_pkg.sv
hdl/redm_in_stage.sv
hdl/redm_core.sv
hdl/rotary_encoder_decoder_with_momentum.sv
tb/rotary_encoder_decoder_with_momentum_tb.sv
